FILE: hdl/dual_loop_pid_with_deadband_top_defines.svh
// Assertion helpers used by the checker file.
`ifndef DUAL_LOOP_PID_WITH_DEADBAND_TOP_DEFINES_SVH
`define DUAL_LOOP_PID_WITH_DEADBAND_TOP_DEFINES_SVH

// Checked only outside reset.
`define DLPID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define DLPID_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/dlpid_pkg.sv
package dlpid_pkg;

  // Field widths
  localparam int REQ_W   = 2;
  localparam int DATA_W  = 16;
  localparam int DRIVE_W = 16;
  localparam int CFG_W   = 48;
  localparam int CIDX_W  = 2;
  localparam int GAIN_W  = 16;

  // Loop structure
  localparam int NUM_LOOPS = 2;
  localparam int LOOP_W    = 1;
  localparam int FRAC_BITS = 8;

  // Internal arithmetic widths
  localparam int ERR_W   = DATA_W + 1;
  localparam int INTEG_W = 32;

  // Error magnitude above which the integral stops accumulating
  localparam int SEP_LIMIT = 1000;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ANGLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SPEED = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_GAINS_ANGLE  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_GAINS_SPEED  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_LIMITS_ANGLE = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_LIMITS_SPEED = 2'd3;

  // Result of one regulation step
  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      dead;
    logic signed [INTEG_W-1:0] integ;
  } calc_res_t;

endpackage

FILE: hdl/dlpid_if.sv
// Request channel
interface dlpid_req_if;
  import dlpid_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] measured;
  logic signed [DATA_W-1:0] target;
  modport source (output valid, req_type, measured, target, input ready);
  modport sink (input valid, req_type, measured, target, output ready);
endinterface

// Result channel
interface dlpid_rsp_if;
  import dlpid_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic                      in_deadband;
  modport source (output valid, drive, in_deadband, input ready);
  modport sink (input valid, drive, in_deadband, output ready);
endinterface

// Configuration write channel
interface dlpid_cfg_if;
  import dlpid_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] reg_index;
  logic [CFG_W-1:0]  wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

FILE: hdl/dlpid_calc.sv
// One PID step for a single loop: P, separated and clamped I, D, output clamp.
module dlpid_calc (
  input  logic [dlpid_pkg::CFG_W-1:0]           gains,
  input  logic [dlpid_pkg::CFG_W-1:0]           limits,
  input  logic signed [dlpid_pkg::ERR_W-1:0]    err,
  input  logic signed [dlpid_pkg::ERR_W-1:0]    prev_err,
  input  logic signed [dlpid_pkg::INTEG_W-1:0]  integ,
  output dlpid_pkg::calc_res_t                  res
);
  import dlpid_pkg::*;

  localparam int PROD_W = ERR_W + GAIN_W + 1;
  localparam int DIFF_W = ERR_W + 1;
  localparam int DPROD_W = DIFF_W + GAIN_W + 1;
  localparam int IACC_W = PROD_W + 1;
  localparam int SUM_W = DPROD_W + 3;
  localparam int SH_W = SUM_W - FRAC_BITS;
  localparam logic signed [SH_W-1:0] DRV_MAX = SH_W'(2 ** (DRIVE_W - 1) - 1);
  localparam logic signed [SH_W-1:0] DRV_MIN = SH_W'(-(2 ** (DRIVE_W - 1)));

  logic [GAIN_W-1:0] kp, ki, kd;
  logic [GAIN_W-1:0] ilim_f, olim, band;
  logic [ERR_W-1:0] mag;
  logic sep;
  logic signed [PROD_W-1:0] p_term, i_term;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DPROD_W-1:0] d_term;
  logic signed [IACC_W-1:0] iacc, ilim, iclamp;
  logic signed [SUM_W-1:0] sum;
  logic signed [SH_W-1:0] sh, olim_s, oclamp, dclamp;

  // Register fields
  assign kp     = gains[GAIN_W-1:0];
  assign ki     = gains[2*GAIN_W-1:GAIN_W];
  assign kd     = gains[3*GAIN_W-1:2*GAIN_W];
  assign ilim_f = limits[GAIN_W-1:0];
  assign olim   = limits[2*GAIN_W-1:GAIN_W];
  assign band   = limits[3*GAIN_W-1:2*GAIN_W];

  // Error magnitude and separation tests
  assign mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign sep = mag <= ERR_W'(SEP_LIMIT);

  // Products
  assign p_term = $signed({1'b0, kp}) * err;
  assign i_term = $signed({1'b0, ki}) * err;
  assign diff   = DIFF_W'(err) - DIFF_W'(prev_err);
  assign d_term = $signed({1'b0, kd}) * diff;

  // Integral update and symmetric clamp
  assign iacc = IACC_W'(integ) + (sep ? IACC_W'(i_term) : '0);
  assign ilim = $signed(IACC_W'({ilim_f, FRAC_BITS'(0)}));

  always_comb begin
    if (iacc > ilim) begin
      iclamp = ilim;
    end else if (iacc < -ilim) begin
      iclamp = -ilim;
    end else begin
      iclamp = iacc;
    end
  end

  // Sum, scale back to integer units, output clamps
  assign sum    = SUM_W'(p_term) + SUM_W'(iclamp) + SUM_W'(d_term);
  assign sh     = SH_W'(sum >>> FRAC_BITS);
  assign olim_s = $signed(SH_W'(olim));

  always_comb begin
    if (sh > olim_s) begin
      oclamp = olim_s;
    end else if (sh < -olim_s) begin
      oclamp = -olim_s;
    end else begin
      oclamp = sh;
    end
    if (oclamp > DRV_MAX) begin
      dclamp = DRV_MAX;
    end else if (oclamp < DRV_MIN) begin
      dclamp = DRV_MIN;
    end else begin
      dclamp = oclamp;
    end
  end

  assign res.dead  = mag < ERR_W'(band);
  assign res.drive = res.dead ? '0 : DRIVE_W'(dclamp);
  assign res.integ = INTEG_W'(iclamp);

endmodule

FILE: hdl/dual_loop_pid_with_deadband_top.sv
// Two-loop positional PID regulator (angle loop and speed loop) with deadband
// and integral separation. A request picks loop 0 or 1, or clears both loops;
// every request gives exactly one result. Throughput is one request per clock
// while results are taken: the request is registered, one pass of logic
// forms P, I and D from the registered request and the selected loop's
// integral and last error, and the result lands in the output register while
// the loop state is written back in the same cycle, so the next request
// already sees it. The output register decouples the two sides; while a
// result waits, the request register takes one more request and then the
// input stalls. Config registers take a write on every cycle and reset to
// zero, as does loop state.
module dual_loop_pid_with_deadband_top (
  input  logic        clk,
  input  logic        rst,
  dlpid_req_if.sink   req,
  dlpid_rsp_if.source rsp,
  dlpid_cfg_if.sink   cfg
);
  import dlpid_pkg::*;

  // Config registers
  logic [CFG_W-1:0] gains [NUM_LOOPS];
  logic [CFG_W-1:0] limits [NUM_LOOPS];

  // Loop state
  logic signed [INTEG_W-1:0] integral_sum [NUM_LOOPS];
  logic signed [ERR_W-1:0]   previous_error [NUM_LOOPS];

  // Request stage
  logic                     s1_valid;
  logic [REQ_W-1:0]         s1_req;
  logic signed [DATA_W-1:0] s1_measured;
  logic signed [DATA_W-1:0] s1_target;

  // Result register
  logic                      out_valid;
  logic signed [DRIVE_W-1:0] out_drive;
  logic                      out_dead;

  logic adv, fire, is_step;
  logic [LOOP_W-1:0] loop;
  logic signed [ERR_W-1:0] err;
  calc_res_t res;

  assign cfg.ready = 1'b1;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LOOPS; i++) begin
        gains[i]  <= '0;
        limits[i] <= '0;
      end
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        CFG_GAINS_ANGLE:  gains[0]  <= cfg.wdata;
        CFG_GAINS_SPEED:  gains[1]  <= cfg.wdata;
        CFG_LIMITS_ANGLE: limits[0] <= cfg.wdata;
        CFG_LIMITS_SPEED: limits[1] <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // Flow control
  assign adv       = !out_valid || rsp.ready;
  assign fire      = s1_valid && adv;
  assign req.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_req      <= req.req_type;
      s1_measured <= req.measured;
      s1_target   <= req.target;
    end
  end

  // Step decode and error
  assign is_step = (s1_req == REQ_ANGLE) || (s1_req == REQ_SPEED);
  assign loop    = s1_req[LOOP_W-1:0];
  assign err     = ERR_W'(s1_target) - ERR_W'(s1_measured);

  dlpid_calc u_calc (
    .gains    (gains[loop]),
    .limits   (limits[loop]),
    .err      (err),
    .prev_err (previous_error[loop]),
    .integ    (integral_sum[loop]),
    .res      (res)
  );

  // Loop state write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LOOPS; i++) begin
        integral_sum[i]   <= '0;
        previous_error[i] <= '0;
      end
    end else if (fire) begin
      if (s1_req == REQ_CLEAR) begin
        for (int i = 0; i < NUM_LOOPS; i++) begin
          integral_sum[i]   <= '0;
          previous_error[i] <= '0;
        end
      end else if (is_step) begin
        previous_error[loop] <= err;
        if (!res.dead) begin
          integral_sum[loop] <= res.integ;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_drive <= is_step ? res.drive : '0;
      out_dead  <= is_step && res.dead;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.drive       = out_drive;
  assign rsp.in_deadband = out_dead;

endmodule

FILE: hdl/dlpid_checker.sv
`include "dual_loop_pid_with_deadband_top_defines.svh"

// Port-level checks on the regulator.
module dlpid_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_valid,
  input logic                                req_ready,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic signed [dlpid_pkg::DRIVE_W-1:0] drive,
  input logic                                in_deadband
);

  // Reset empties the result register
  `DLPID_ASSERT_ALWAYS(a_rst_empty, rst |=> !rsp_valid, "result valid after reset")

  // A deadband result never drives
  `DLPID_ASSERT(a_dead_zero, (rsp_valid && in_deadband) |-> (drive == '0), "drive in deadband")

  // With the result register empty, an offered request is always taken
  `DLPID_ASSERT(a_ready_empty, (req_valid && !rsp_valid) |-> req_ready, "request blocked")

  // A stalled result stays offered
  `DLPID_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> rsp_valid, "result dropped while stalled")

endmodule

bind dual_loop_pid_with_deadband_top dlpid_checker u_dlpid_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .drive       (rsp.drive),
  .in_deadband (rsp.in_deadband)
);
